### rtl/rgbhd_pkg.sv
// ----------------------------------------------------------------------------
// rgbhd_pkg
// Shared constants, types and helpers for the per-channel Huffman tree
// builder and decoder.
// ----------------------------------------------------------------------------
package rgbhd_pkg;

  localparam int SymbolCount  = 256;
  localparam int NumCh        = 3;
  localparam int NodeMax      = 2 * SymbolCount - 1;
  localparam int MaxRowPixels = 8192;

  localparam int SymW      = 8;
  localparam int ChW       = 2;
  localparam int FreqW     = 24;
  localparam int CntW      = 32;
  localparam int NodeW     = 9;
  localparam int PprW      = 14;
  localparam int PosW      = 15;
  localparam int VbW       = 4;

  localparam int FreqDepth = 1024;
  localparam int FreqAddrW = 10;
  localparam int ClearLast = NumCh * SymbolCount - 1;
  localparam int SortDepth = SymbolCount;
  localparam int SortAddrW = 8;
  localparam int TreeDepth = NumCh * NodeMax;
  localparam int TreeAddrW = 11;

  // input item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  localparam logic [ChW-1:0] CH_BAD = 2'd3;

  typedef struct packed {
    logic             internal;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
  } tree_node_t;

  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [NodeW-1:0] node;
  } sort_entry_t;

  typedef struct packed {
    logic                 we;
    logic [TreeAddrW-1:0] addr;
    tree_node_t           data;
  } tree_wr_t;

  typedef struct packed {
    logic [SymW-1:0] value;
    logic            pad;
    logic [ChW-1:0]  ch;
  } result_t;

  typedef logic [NumCh-1:0][NodeW-1:0] root_set_t;

  // flat tree address of a node within its channel's region
  function automatic logic [TreeAddrW-1:0] tree_addr(input logic [ChW-1:0] ch,
                                                     input logic [NodeW-1:0] node);
    return TreeAddrW'(ch) * TreeAddrW'(NodeMax) + TreeAddrW'(node);
  endfunction

endpackage

### rtl/rgb_huffman_tree_build_and_decode_unit.sv
// ----------------------------------------------------------------------------
// rgb_huffman_tree_build_and_decode_unit
// Per-channel Huffman tree builder and bit-serial decoder for BGR rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries load, build and decode items.
//   Loads write one symbol count, builds make all three trees, decodes feed
//   up to eight code bits. Loads and builds give no results; a decode gives
//   zero to twelve result transfers on the out_valid/out_ready channel, the
//   final one flagged by last.
//   Steps: a load is one write to the frequency memory. A decode walks each
//   bit through decide, evaluate and child read, plus an extra tree read for
//   each bit that starts at a root, and one step per emitted or padding byte;
//   the single read port of the tree memory sets this pace. A build is paced
//   by the insertion steps on the sort list memory (one read and one write
//   per step) for each used symbol and each merge.
//   Reset: a clearing pass over 768 entries zeroes the frequency memory, with
//   in_ready low; the width register may be written meanwhile.
//   Stall: results wait in an output register and one held result; when the
//   receiver stalls the walk pauses and in_ready stays low until the item
//   has finished.
// ----------------------------------------------------------------------------
module rgb_huffman_tree_build_and_decode_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [rgbhd_pkg::ChW-1:0]     channel,
  input  logic [rgbhd_pkg::SymW-1:0]    symbol,
  input  logic [rgbhd_pkg::FreqW-1:0]   count,
  input  logic [rgbhd_pkg::SymW-1:0]    code_byte,
  input  logic [rgbhd_pkg::VbW-1:0]     valid_bits,
  input  logic                          cfg_we,
  input  logic [rgbhd_pkg::PprW-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbhd_pkg::SymW-1:0]    out_byte,
  output logic                          is_padding,
  output logic [rgbhd_pkg::ChW-1:0]     out_channel,
  output logic                          last
);

  logic                           acc;
  logic                           b_busy;
  logic                           b_done;
  logic                           d_busy;
  rgbhd_pkg::root_set_t           roots;
  rgbhd_pkg::tree_wr_t            tree_wr;
  logic [rgbhd_pkg::TreeAddrW-1:0] tree_raddr;
  rgbhd_pkg::tree_node_t          tree_rd;
  rgbhd_pkg::result_t             res;

  // one item at a time
  assign in_ready    = !b_busy && !d_busy;
  assign acc         = in_valid && in_ready;
  assign out_byte    = res.value;
  assign is_padding  = res.pad;
  assign out_channel = res.ch;

  rgbhd_build u_build (
    .clk        (clk),
    .rst        (rst),
    .load_we    (acc && mode == rgbhd_pkg::MODE_LOAD),
    .load_ch    (channel),
    .load_sym   (symbol),
    .load_cnt   (count),
    .build_start(acc && mode == rgbhd_pkg::MODE_BUILD),
    .busy       (b_busy),
    .done       (b_done),
    .roots      (roots),
    .tree_wr    (tree_wr)
  );

  rgbhd_ram #(.Width($bits(rgbhd_pkg::tree_node_t)), .Depth(rgbhd_pkg::TreeDepth)) u_tree (
    .clk  (clk),
    .we   (tree_wr.we),
    .waddr(tree_wr.addr),
    .wdata(tree_wr.data),
    .raddr(tree_raddr),
    .rdata(tree_rd)
  );

  rgbhd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .start     (acc && mode == rgbhd_pkg::MODE_DECODE),
    .code_in   (code_byte),
    .vb_in     (valid_bits),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .restart   (b_done),
    .roots     (roots),
    .tree_raddr(tree_raddr),
    .tree_rd   (tree_rd),
    .busy      (d_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (last)
  );

endmodule

### rtl/rgbhd_ram.sv
// ----------------------------------------------------------------------------
// rgbhd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rgbhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rgbhd_build.sv
// ----------------------------------------------------------------------------
// rgbhd_build
// Frequency table, sort list and tree construction sequencer.
// ----------------------------------------------------------------------------
module rgbhd_build (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load_we,
  input  logic [rgbhd_pkg::ChW-1:0]      load_ch,
  input  logic [rgbhd_pkg::SymW-1:0]     load_sym,
  input  logic [rgbhd_pkg::FreqW-1:0]    load_cnt,
  input  logic                           build_start,
  output logic                           busy,
  output logic                           done,
  output rgbhd_pkg::root_set_t           roots,
  output rgbhd_pkg::tree_wr_t            tree_wr
);

  typedef enum logic [11:0] {
    B_CLEAR   = 12'b000000000001,
    B_IDLE    = 12'b000000000010,
    B_START   = 12'b000000000100,
    B_SCAN_RD = 12'b000000001000,
    B_SCAN_CK = 12'b000000010000,
    B_INS     = 12'b000000100000,
    B_INS_W   = 12'b000001000000,
    B_MRG_CK  = 12'b000010000000,
    B_MRG_R2  = 12'b000100000000,
    B_MRG_C   = 12'b001000000000,
    B_ROOT    = 12'b010000000000,
    B_NEXT    = 12'b100000000000
  } build_state_t;

  build_state_t state;

  logic [rgbhd_pkg::FreqAddrW-1:0] clr_addr;
  logic [rgbhd_pkg::ChW-1:0]       ch;
  logic [rgbhd_pkg::NodeW-1:0]     sym;
  logic [rgbhd_pkg::NodeW-1:0]     n;
  logic [rgbhd_pkg::NodeW-1:0]     end_pos;
  logic [rgbhd_pkg::NodeW-1:0]     next;
  logic [rgbhd_pkg::NodeW-1:0]     j;
  logic [rgbhd_pkg::NodeW-1:0]     j_dec;
  logic [rgbhd_pkg::NodeW-1:0]     c0;
  logic [rgbhd_pkg::CntW-1:0]      c0_cnt;
  logic                            from_merge;
  rgbhd_pkg::sort_entry_t          key;

  logic                            f_we;
  logic [rgbhd_pkg::FreqAddrW-1:0] f_waddr;
  logic [rgbhd_pkg::FreqW-1:0]     f_wdata;
  logic [rgbhd_pkg::FreqAddrW-1:0] f_raddr;
  logic [rgbhd_pkg::FreqW-1:0]     f_rdata;

  logic                            s_we;
  logic [rgbhd_pkg::SortAddrW-1:0] s_waddr;
  rgbhd_pkg::sort_entry_t          s_wdata;
  logic [rgbhd_pkg::SortAddrW-1:0] s_raddr;
  rgbhd_pkg::sort_entry_t          s_rd;

  logic                            shift_down;

  assign busy       = (state != B_IDLE);
  assign j_dec      = j - 1'b1;
  assign shift_down = (s_rd.cnt < key.cnt);

  rgbhd_ram #(.Width(rgbhd_pkg::FreqW), .Depth(rgbhd_pkg::FreqDepth)) u_freq (
    .clk  (clk),
    .we   (f_we),
    .waddr(f_waddr),
    .wdata(f_wdata),
    .raddr(f_raddr),
    .rdata(f_rdata)
  );

  rgbhd_ram #(.Width($bits(rgbhd_pkg::sort_entry_t)), .Depth(rgbhd_pkg::SortDepth)) u_sort (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rd)
  );

  // memory port control per state
  always_comb begin
    f_we    = 1'b0;
    f_waddr = clr_addr;
    f_wdata = '0;
    f_raddr = {ch, sym[rgbhd_pkg::SymW-1:0]};
    s_we    = 1'b0;
    s_waddr = j[rgbhd_pkg::SortAddrW-1:0];
    s_wdata = key;
    s_raddr = j_dec[rgbhd_pkg::SortAddrW-1:0];
    tree_wr = '0;
    case (state)
      B_CLEAR: begin
        f_we = 1'b1;
      end
      B_IDLE: begin
        if (load_we && load_ch != rgbhd_pkg::CH_BAD) begin
          f_we    = 1'b1;
          f_waddr = {load_ch, load_sym};
          f_wdata = load_cnt;
        end
      end
      B_SCAN_CK: begin
        if (f_rdata != '0) begin
          tree_wr.we            = 1'b1;
          tree_wr.addr          = rgbhd_pkg::tree_addr(ch, n);
          tree_wr.data.internal = 1'b0;
          tree_wr.data.a        = sym;
          tree_wr.data.b        = '0;
        end
      end
      B_INS: begin
        if (j == '0) begin
          s_we    = 1'b1;
          s_waddr = '0;
        end
      end
      B_INS_W: begin
        s_we = 1'b1;
        if (shift_down) begin
          s_wdata = s_rd;
        end
      end
      B_MRG_CK: begin
        if (end_pos > rgbhd_pkg::NodeW'(1)) begin
          s_raddr = rgbhd_pkg::SortAddrW'(end_pos - 1'b1);
        end else if (n == '0) begin
          tree_wr.we   = 1'b1;
          tree_wr.addr = rgbhd_pkg::tree_addr(ch, '0);
        end else begin
          s_raddr = '0;
        end
      end
      B_MRG_R2: begin
        s_raddr = rgbhd_pkg::SortAddrW'(end_pos - 2'd2);
      end
      B_MRG_C: begin
        tree_wr.we            = 1'b1;
        tree_wr.addr          = rgbhd_pkg::tree_addr(ch, next);
        tree_wr.data.internal = 1'b1;
        tree_wr.data.a        = c0;
        tree_wr.data.b        = s_rd.node;
      end
      default: begin
      end
    endcase
  end

  // build sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      roots    <= '0;
      done     <= 1'b0;
    end else begin
      done <= (state == B_NEXT) && (ch == rgbhd_pkg::ChW'(rgbhd_pkg::NumCh - 1));
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == rgbhd_pkg::FreqAddrW'(rgbhd_pkg::ClearLast)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (build_start) begin
            ch    <= '0;
            state <= B_START;
          end
        end
        B_START: begin
          sym   <= '0;
          n     <= '0;
          state <= B_SCAN_RD;
        end
        B_SCAN_RD: begin
          if (sym == rgbhd_pkg::NodeW'(rgbhd_pkg::SymbolCount)) begin
            end_pos <= n;
            next    <= n;
            state   <= B_MRG_CK;
          end else begin
            state <= B_SCAN_CK;
          end
        end
        B_SCAN_CK: begin
          sym <= sym + 1'b1;
          if (f_rdata != '0) begin
            key.cnt    <= rgbhd_pkg::CntW'(f_rdata);
            key.node   <= n;
            j          <= n;
            n          <= n + 1'b1;
            from_merge <= 1'b0;
            state      <= B_INS;
          end else begin
            state <= B_SCAN_RD;
          end
        end
        B_INS: begin
          if (j == '0) begin
            state <= from_merge ? B_MRG_CK : B_SCAN_RD;
          end else begin
            state <= B_INS_W;
          end
        end
        B_INS_W: begin
          if (shift_down) begin
            j     <= j_dec;
            state <= B_INS;
          end else begin
            state <= from_merge ? B_MRG_CK : B_SCAN_RD;
          end
        end
        B_MRG_CK: begin
          if (end_pos > rgbhd_pkg::NodeW'(1)) begin
            state <= B_MRG_R2;
          end else if (n == '0) begin
            roots[ch] <= '0;
            state     <= B_NEXT;
          end else begin
            state <= B_ROOT;
          end
        end
        B_MRG_R2: begin
          c0     <= s_rd.node;
          c0_cnt <= s_rd.cnt;
          state  <= B_MRG_C;
        end
        B_MRG_C: begin
          key.cnt    <= c0_cnt + s_rd.cnt;
          key.node   <= next;
          j          <= end_pos - 2'd2;
          end_pos    <= end_pos - 1'b1;
          next       <= next + 1'b1;
          from_merge <= 1'b1;
          state      <= B_INS;
        end
        B_ROOT: begin
          roots[ch] <= s_rd.node;
          state     <= B_NEXT;
        end
        B_NEXT: begin
          if (ch == rgbhd_pkg::ChW'(rgbhd_pkg::NumCh - 1)) begin
            state <= B_IDLE;
          end else begin
            ch    <= ch + 1'b1;
            state <= B_START;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rgbhd_decode.sv
// ----------------------------------------------------------------------------
// rgbhd_decode
// Bit-serial tree walk, row position tracking and result output stage.
// ----------------------------------------------------------------------------
module rgbhd_decode (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rgbhd_pkg::SymW-1:0]       code_in,
  input  logic [rgbhd_pkg::VbW-1:0]        vb_in,
  input  logic                             cfg_we,
  input  logic [rgbhd_pkg::PprW-1:0]       cfg_wdata,
  input  logic                             restart,
  input  rgbhd_pkg::root_set_t             roots,
  output logic [rgbhd_pkg::TreeAddrW-1:0]  tree_raddr,
  input  rgbhd_pkg::tree_node_t            tree_rd,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rgbhd_pkg::result_t               out_res,
  output logic                             out_last
);

  typedef enum logic [7:0] {
    D_IDLE  = 8'b00000001,
    D_BIT   = 8'b00000010,
    D_CUR   = 8'b00000100,
    D_EVAL  = 8'b00001000,
    D_CHILD = 8'b00010000,
    D_EMIT  = 8'b00100000,
    D_PAD   = 8'b01000000,
    D_FIN   = 8'b10000000
  } dec_state_t;

  dec_state_t state;

  logic [rgbhd_pkg::PprW-1:0]  ppr;
  logic [rgbhd_pkg::PosW-1:0]  pos;
  logic [rgbhd_pkg::ChW-1:0]   mod3;
  logic [rgbhd_pkg::NodeW-1:0] cur;
  logic                        cur_known;
  rgbhd_pkg::tree_node_t       cur_data;
  logic [rgbhd_pkg::NodeW-1:0] child_r;
  logic [rgbhd_pkg::SymW-1:0]  code;
  logic [rgbhd_pkg::VbW-1:0]   vb;
  logic [rgbhd_pkg::VbW-1:0]   bitidx;
  logic [1:0]                  pad_left;
  logic [rgbhd_pkg::SymW-1:0]  emit_sym;
  rgbhd_pkg::result_t          pend;
  logic                        pend_valid;

  logic [rgbhd_pkg::PprW-1:0]  p_cl;
  logic [rgbhd_pkg::PosW-1:0]  data_bytes;
  logic [1:0]                  pad_cnt;
  logic [rgbhd_pkg::PosW-1:0]  new_pos;
  logic [rgbhd_pkg::ChW-1:0]   mod3_next;
  logic                        bit_val;
  logic [rgbhd_pkg::NodeW-1:0] child;
  logic                        can_push;
  logic                        room;
  logic                        push;

  // row geometry from the clamped width
  always_comb begin
    if (ppr == '0) begin
      p_cl = rgbhd_pkg::PprW'(1);
    end else if (ppr > rgbhd_pkg::PprW'(rgbhd_pkg::MaxRowPixels)) begin
      p_cl = rgbhd_pkg::PprW'(rgbhd_pkg::MaxRowPixels);
    end else begin
      p_cl = ppr;
    end
  end

  assign data_bytes = rgbhd_pkg::PosW'(p_cl) + (rgbhd_pkg::PosW'(p_cl) << 1);
  assign pad_cnt    = p_cl[1:0];
  assign new_pos    = pos + 1'b1;
  assign mod3_next  = (mod3 == rgbhd_pkg::ChW'(2)) ? '0 : mod3 + 1'b1;
  assign bit_val    = code[~bitidx[2:0]];
  assign child      = bit_val ? cur_data.b : cur_data.a;
  assign can_push   = !out_valid || out_ready;
  assign room       = !pend_valid || can_push;
  assign push       = pend_valid && can_push && (state inside {D_EMIT, D_PAD, D_FIN});
  assign busy       = (state != D_IDLE);

  // tree read address
  always_comb begin
    case (state)
      D_EVAL:  tree_raddr = rgbhd_pkg::tree_addr(mod3, child);
      default: tree_raddr = rgbhd_pkg::tree_addr(mod3, cur);
    endcase
  end

  // walk sequencer and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= D_IDLE;
      ppr        <= rgbhd_pkg::PprW'(1);
      pos        <= '0;
      mod3       <= '0;
      cur        <= '0;
      cur_known  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we || restart) begin
        pos       <= '0;
        mod3      <= '0;
        cur       <= roots[0];
        cur_known <= 1'b0;
      end
      if (cfg_we) begin
        ppr <= cfg_wdata;
      end
      case (state)
        D_IDLE: begin
          if (start) begin
            code   <= code_in;
            vb     <= (vb_in > rgbhd_pkg::VbW'(8)) ? rgbhd_pkg::VbW'(8) : vb_in;
            bitidx <= '0;
            if (pos >= data_bytes && !cfg_we && !restart) begin
              pos       <= '0;
              mod3      <= '0;
              cur_known <= 1'b0;
            end
            state <= D_BIT;
          end
        end
        D_BIT: begin
          if (bitidx == vb) begin
            state <= D_FIN;
          end else if (cur_known) begin
            state <= D_EVAL;
          end else begin
            state <= D_CUR;
          end
        end
        D_CUR: begin
          cur_data  <= tree_rd;
          cur_known <= 1'b1;
          state     <= D_EVAL;
        end
        D_EVAL: begin
          if (cur_data.internal) begin
            child_r <= child;
            state   <= D_CHILD;
          end else begin
            emit_sym <= cur_data.a[rgbhd_pkg::SymW-1:0];
            state    <= D_EMIT;
          end
        end
        D_CHILD: begin
          if (tree_rd.internal) begin
            cur      <= child_r;
            cur_data <= tree_rd;
            bitidx   <= bitidx + 1'b1;
            state    <= D_BIT;
          end else begin
            emit_sym <= tree_rd.a[rgbhd_pkg::SymW-1:0];
            state    <= D_EMIT;
          end
        end
        D_EMIT: begin
          if (room) begin
            if (pend_valid) begin
              out_res   <= pend;
              out_last  <= 1'b0;
            end
            pend.value <= emit_sym;
            pend.pad   <= 1'b0;
            pend.ch    <= mod3;
            pend_valid <= 1'b1;
            bitidx     <= bitidx + 1'b1;
            cur_known  <= 1'b0;
            if (new_pos >= data_bytes) begin
              pos  <= '0;
              mod3 <= '0;
              cur  <= roots[0];
              if (pad_cnt != '0) begin
                pad_left <= pad_cnt;
                state    <= D_PAD;
              end else begin
                state <= D_BIT;
              end
            end else begin
              pos   <= new_pos;
              mod3  <= mod3_next;
              cur   <= roots[mod3_next];
              state <= D_BIT;
            end
          end
        end
        D_PAD: begin
          if (room) begin
            if (pend_valid) begin
              out_res   <= pend;
              out_last  <= 1'b0;
            end
            pend.value <= '0;
            pend.pad   <= 1'b1;
            pend.ch    <= '0;
            pend_valid <= 1'b1;
            pad_left   <= pad_left - 1'b1;
            if (pad_left == 2'd1) begin
              state <= D_BIT;
            end
          end
        end
        D_FIN: begin
          if (!pend_valid) begin
            state <= D_IDLE;
          end else if (can_push) begin
            out_res    <= pend;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rgbhd_checker.sv
// ----------------------------------------------------------------------------
// rgbhd_checker
// Port-level checks for the Huffman decode unit, bound to the top level.
// ----------------------------------------------------------------------------
module rgbhd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rgbhd_pkg::SymW-1:0]  out_byte,
  input logic                        is_padding,
  input logic [rgbhd_pkg::ChW-1:0]   out_channel,
  input logic                        last
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("result changed while stalled");

  // padding bytes are zero with channel zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_padding |-> out_byte == '0 && out_channel == '0)
    else $error("padding byte not zero");

  // channel code in range
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_channel != 2'd3)
    else $error("bad output channel");

  // clearing pass blocks input after reset
  a_reset_block: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

endmodule

bind rgb_huffman_tree_build_and_decode_unit rgbhd_checker u_chk (.*);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-channel Huffman tree builder and decoder.
// Frequency loads, tree builds and decode bytes are driven in random bursts.
// A local tree model predicts every decoded and padding byte. The monitor
// checks each output transfer against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [1:0]                  mode;
    logic [rgbhd_pkg::ChW-1:0]   channel;
    logic [rgbhd_pkg::SymW-1:0]  symbol;
    logic [rgbhd_pkg::FreqW-1:0] count;
    logic [rgbhd_pkg::SymW-1:0]  code_byte;
    logic [rgbhd_pkg::VbW-1:0]   valid_bits;
  } cmd_t;

  typedef struct {
    logic [rgbhd_pkg::SymW-1:0] value;
    logic                       pad;
    logic [rgbhd_pkg::ChW-1:0]  ch;
    logic                       last;
  } byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [rgbhd_pkg::ChW-1:0] channel = '0;
  logic [rgbhd_pkg::SymW-1:0] symbol = '0;
  logic [rgbhd_pkg::FreqW-1:0] count = '0;
  logic [rgbhd_pkg::SymW-1:0] code_byte = '0;
  logic [rgbhd_pkg::VbW-1:0] valid_bits = '0;
  logic cfg_we = 1'b0;
  logic [rgbhd_pkg::PprW-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rgbhd_pkg::SymW-1:0] out_byte;
  logic is_padding;
  logic [rgbhd_pkg::ChW-1:0] out_channel;
  logic last;

  rgb_huffman_tree_build_and_decode_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .channel(channel), .symbol(symbol), .count(count),
    .code_byte(code_byte), .valid_bits(valid_bits),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .is_padding(is_padding),
    .out_channel(out_channel), .last(last)
  );

  always #10 clk = ~clk;

  // decoder model state
  int unsigned freq [rgbhd_pkg::NumCh][rgbhd_pkg::SymbolCount];
  bit          node_int [rgbhd_pkg::NumCh][rgbhd_pkg::NodeMax];
  int          node_a [rgbhd_pkg::NumCh][rgbhd_pkg::NodeMax];
  int          node_b [rgbhd_pkg::NumCh][rgbhd_pkg::NodeMax];
  int          roots [rgbhd_pkg::NumCh];
  int          walk_node;
  int          row_pos;
  int          width_px;
  int          order_node [rgbhd_pkg::SymbolCount];
  longint      order_cnt [rgbhd_pkg::SymbolCount];

  cmd_t  pending_cmds [$];
  byte_t expected_bytes [$];
  int    errors = 0;
  bit    hold_req = 1'b0;

  // huffman tree of one channel
  function automatic void build_tree(int ch);
    int n, tail, nxt, i, j, tn;
    longint tc, sum;
    int c0, c1;
    n = 0;
    for (i = 0; i < rgbhd_pkg::SymbolCount; i++) begin
      if (freq[ch][i] != 0) begin
        node_int[ch][n] = 1'b0;
        node_a[ch][n] = i;
        node_b[ch][n] = 0;
        order_node[n] = n;
        order_cnt[n] = freq[ch][i];
        n++;
      end
    end
    for (i = 1; i < n; i++) begin
      for (j = i; j > 0 && order_cnt[j] > order_cnt[j-1]; j--) begin
        tn = order_node[j-1]; tc = order_cnt[j-1];
        order_node[j-1] = order_node[j]; order_cnt[j-1] = order_cnt[j];
        order_node[j] = tn; order_cnt[j] = tc;
      end
    end
    tail = n;
    nxt = n;
    while (tail > 1 && nxt < rgbhd_pkg::NodeMax) begin
      c0 = order_node[tail-1];
      c1 = order_node[tail-2];
      sum = order_cnt[tail-1] + order_cnt[tail-2];
      tail -= 2;
      i = tail;
      while (i > 0 && order_cnt[i-1] < sum) begin
        order_node[i] = order_node[i-1];
        order_cnt[i] = order_cnt[i-1];
        i--;
      end
      node_int[ch][nxt] = 1'b1;
      node_a[ch][nxt] = c0;
      node_b[ch][nxt] = c1;
      order_node[i] = nxt;
      order_cnt[i] = sum;
      nxt++;
      tail++;
    end
    if (n == 0) begin
      node_int[ch][0] = 1'b0;
      node_a[ch][0] = 0;
      node_b[ch][0] = 0;
      roots[ch] = 0;
    end else begin
      roots[ch] = order_node[0];
    end
  endfunction

  function automatic void push_byte(int value, bit pad, int ch);
    byte_t b;
    b.value = value[7:0];
    b.pad = pad;
    b.ch = ch[1:0];
    b.last = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  // expected bytes for one accepted command
  function automatic void predict_cmd(cmd_t c);
    int vb, i, ch, nd, px, data_bytes, row_bytes, produced;
    byte_t b;
    case (c.mode)
      rgbhd_pkg::MODE_LOAD: begin
        if (c.channel != rgbhd_pkg::CH_BAD) freq[c.channel][c.symbol] = c.count;
      end
      rgbhd_pkg::MODE_BUILD: begin
        for (i = 0; i < rgbhd_pkg::NumCh; i++) build_tree(i);
        row_pos = 0;
        walk_node = roots[0];
      end
      rgbhd_pkg::MODE_DECODE: begin
        px = width_px < 1 ? 1 :
             (width_px > rgbhd_pkg::MaxRowPixels ? rgbhd_pkg::MaxRowPixels : width_px);
        data_bytes = 3 * px;
        row_bytes = data_bytes + ((4 - data_bytes % 4) % 4);
        if (row_pos >= data_bytes) row_pos = 0;
        vb = c.valid_bits > 8 ? 8 : c.valid_bits;
        produced = 0;
        for (i = 0; i < vb; i++) begin
          ch = row_pos % 3;
          nd = walk_node;
          if (nd >= rgbhd_pkg::NodeMax) nd = 0;
          if (node_int[ch][nd]) begin
            nd = c.code_byte[7-i] ? node_b[ch][nd] : node_a[ch][nd];
            if (nd >= rgbhd_pkg::NodeMax) nd = 0;
            if (node_int[ch][nd]) begin
              walk_node = nd;
              continue;
            end
          end
          push_byte(node_a[ch][nd], 1'b0, ch);
          produced++;
          row_pos++;
          if (row_pos >= data_bytes) begin
            while (row_pos < row_bytes) begin
              push_byte(0, 1'b1, 0);
              produced++;
              row_pos++;
            end
            row_pos = 0;
          end
          walk_node = roots[row_pos % 3];
        end
        if (produced > 0) begin
          b = expected_bytes.pop_back();
          b.last = 1'b1;
          expected_bytes.push_back(b);
        end
      end
      default: ;
    endcase
  endfunction

  // sender: bursts with random gaps
  cmd_t cur_cmd;
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_cmd(cur_cmd);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          mode <= cur_cmd.mode;
          channel <= cur_cmd.channel;
          symbol <= cur_cmd.symbol;
          count <= cur_cmd.count;
          code_byte <= cur_cmd.code_byte;
          valid_bits <= cur_cmd.valid_bits;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int rx_style = 0;
  int rx_left = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_cnt < 600) begin
      hold_cnt++;
      if (hold_cnt == 600) hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result check against oldest prediction
  byte_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected transfer byte=%0h pad=%0b ch=%0d last=%0b",
                 $time, out_byte, is_padding, out_channel, last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value || is_padding !== want.pad ||
            out_channel !== want.ch || last !== want.last) begin
          $display("%0t: mismatch expected byte=%0h pad=%0b ch=%0d last=%0b",
                   $time, want.value, want.pad, want.ch, want.last);
          $display("%0t:          actual   byte=%0h pad=%0b ch=%0d last=%0b",
                   $time, out_byte, is_padding, out_channel, last);
          errors++;
        end
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] m, int ch, int sym, int cnt, int cb, int vb);
    cmd_t c;
    c.mode = m;
    c.channel = ch[1:0];
    c.symbol = sym[7:0];
    c.count = cnt[23:0];
    c.code_byte = cb[7:0];
    c.valid_bits = vb[3:0];
    return c;
  endfunction

  task automatic drain_and_settle();
    while (pending_cmds.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (25000) @(posedge clk);
  endtask

  // width register write, with the model's row position and walk reset
  task automatic write_width(int value);
    cfg_we <= 1'b1;
    cfg_wdata <= value[rgbhd_pkg::PprW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    width_px = value & 16'h3FFF;
    row_pos = 0;
    walk_node = roots[0];
  endtask

  // random phase: fresh tables, build, decode stream, with some malformed items
  task automatic random_phase(int decodes);
    int ch, k, n;
    for (ch = 0; ch < rgbhd_pkg::NumCh; ch++) begin
      for (k = 0; k < rgbhd_pkg::SymbolCount; k++) begin
        if (freq[ch][k] != 0)
          pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, ch, k, 0, 0, 0));
      end
      n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 10);
      for (k = 0; k < n; k++) begin
        pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, ch, $urandom_range(0, 255),
          $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 24'hFFFFFF),
          0, 0));
      end
    end
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, rgbhd_pkg::CH_BAD,
                              $urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF), 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_BUILD, $urandom_range(0, 3), $urandom,
                              $urandom, $urandom, $urandom));
    for (k = 0; k < decodes; k++) begin
      if ($urandom_range(0, 19) == 0)
        pending_cmds.push_back(mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
      else
        pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, $urandom, $urandom, $urandom,
          $urandom_range(0, 255),
          $urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8)));
    end
  endtask

  // model is zero as the block is after its clearing pass
  initial begin
    int ch, k, ph;
    int widths [6];
    widths = '{2, 8192, 3, 5, 16383, 1};
    for (ch = 0; ch < rgbhd_pkg::NumCh; ch++) begin
      for (k = 0; k < rgbhd_pkg::SymbolCount; k++) freq[ch][k] = 0;
      roots[ch] = 0;
    end
    walk_node = 0;
    row_pos = 0;
    width_px = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_width(0);

    // directed: extremes, ties, single-symbol and empty channels
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 0, 0, 24'hFFFFFF, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 0, 255, 1, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 0, 7, 1, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 0, 9, 2, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 1, 200, 3, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, rgbhd_pkg::CH_BAD, 5, 77, 0, 0));
    pending_cmds.push_back(mk(MODE_NONE, 3, 255, 24'hFFFFFF, 255, 15));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_BUILD, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'hFF, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'h00, 8));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'hFF, 15));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'hA5, 1));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'h5A, 9));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 3, 255, 24'hFFFFFF, 8'hC3, 7));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 2, 128, 4, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 2, 129, 4, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_LOAD, 2, 130, 4, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_BUILD, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'h6B, 8));
    pending_cmds.push_back(mk(rgbhd_pkg::MODE_DECODE, 0, 0, 0, 8'h94, 8));
    drain_and_settle();

    // random phases across several widths
    for (ph = 0; ph < 6; ph++) begin
      write_width(widths[ph]);
      random_phase(30);
      if (ph == 2) begin
        while (pending_cmds.size() > 30) @(posedge clk);
        hold_req = 1'b1;
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(20 * 3000000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
